// ----- src/dbl_pkg.sv -----
// ----------------------------------------------------------------------------
// dbl_pkg
// Shared types and constants for the DMA block and linked-list walker.
// ----------------------------------------------------------------------------
`default_nettype none

package dbl_pkg;

    typedef enum logic [1:0] {
        KIND_BLOCK = 2'd0,
        KIND_OTC   = 2'd1,
        KIND_LIST  = 2'd2
    } t_kind;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [31:0] OT_END     = 32'h00FF_FFFF;
    localparam int unsigned LL_END_BIT = 23;
    localparam int unsigned LL_SIZE_LO = 24;

    localparam int unsigned COUNT_BITS = 24;

endpackage

`default_nettype wire

// ----- src/dma_block_and_list_walker_top.sv -----
// Latency: a result is valid the cycle after its item is accepted.
// Throughput: one item per cycle while o_in_ready is high; the transfer state
// updates on each accepted item; the result register frees as soon as taken.
// Reset: synchronous, active low; clears the transfer state (block idle)
// and empties the result register.
// ----------------------------------------------------------------------------
// dma_block_and_list_walker_top
// DMA sequencer for block, ordering-table clear and linked-list transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_block_and_list_walker_top
    import dbl_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 21
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_mode,
    input  wire logic [1:0]            i_transfer_kind,
    input  wire logic [ADDR_BITS-1:0]  i_start_address,
    input  wire logic [COUNT_BITS-1:0] i_word_count,
    input  wire logic                  i_step_back,
    input  wire logic [31:0]           i_read_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_mem_op,
    output logic [ADDR_BITS-1:0]       o_mem_address,
    output logic [31:0]                o_mem_write_data,
    output logic                       o_gpu_valid,
    output logic [31:0]                o_gpu_word,
    output logic                       o_done_res,
    output logic                       o_error
);

    logic                 w_fire;
    logic                 w_busy;
    logic [1:0]           w_mem_op;
    logic [ADDR_BITS-1:0] w_mem_address;
    logic [31:0]          w_mem_write_data;
    logic                 w_gpu_valid;
    logic [31:0]          w_gpu_word;
    logic                 w_done_res;
    logic                 w_error;

    logic                 r_out_valid;
    logic [1:0]           r_mem_op;
    logic [ADDR_BITS-1:0] r_mem_address;
    logic [31:0]          r_mem_write_data;
    logic                 r_gpu_valid;
    logic [31:0]          r_gpu_word;
    logic                 r_done_res;
    logic                 r_error;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    dbl_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_mode           (i_mode),
        .i_transfer_kind  (i_transfer_kind),
        .i_start_address  (i_start_address),
        .i_word_count     (i_word_count),
        .i_step_back      (i_step_back),
        .i_read_data      (i_read_data),
        .o_busy           (w_busy),
        .o_mem_op         (w_mem_op),
        .o_mem_address    (w_mem_address),
        .o_mem_write_data (w_mem_write_data),
        .o_gpu_valid      (w_gpu_valid),
        .o_gpu_word       (w_gpu_word),
        .o_done_res       (w_done_res),
        .o_error          (w_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_mem_op         <= w_mem_op;
            r_mem_address    <= w_mem_address;
            r_mem_write_data <= w_mem_write_data;
            r_gpu_valid      <= w_gpu_valid;
            r_gpu_word       <= w_gpu_word;
            r_done_res       <= w_done_res;
            r_error          <= w_error;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mem_op         = r_mem_op;
    assign o_mem_address    = r_mem_address;
    assign o_mem_write_data = r_mem_write_data;
    assign o_gpu_valid      = r_gpu_valid;
    assign o_gpu_word       = r_gpu_word;
    assign o_done_res       = r_done_res;
    assign o_error          = r_error;

    // a response with no transfer running is rejected
    a_idle_resp_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_mode && !w_busy) |=> (o_out_valid && o_error))
        else $error("idle response not flagged");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |->
            (o_mem_op == MEM_NONE && !o_gpu_valid && !o_done_res))
        else $error("error item carries other fields");

    a_done_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_mem_op == MEM_NONE))
        else $error("done item issues a memory request");

    a_otc_start_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !i_mode && !w_busy && i_transfer_kind == KIND_OTC
            && i_word_count != '0) |=> (o_mem_op == MEM_WRITE && !o_error))
        else $error("table clear did not start with a write");

    a_busy_drops_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_done_res) |=> !w_busy)
        else $error("block still busy after done");

endmodule

`default_nettype wire

// ----- src/dbl_core.sv -----
// ----------------------------------------------------------------------------
// dbl_core
// Transfer state and next-state logic: one item is applied per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_core
    import dbl_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 21
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire logic                  i_mode,
    input  wire logic [1:0]            i_transfer_kind,
    input  wire logic [ADDR_BITS-1:0]  i_start_address,
    input  wire logic [COUNT_BITS-1:0] i_word_count,
    input  wire logic                  i_step_back,
    input  wire logic [31:0]           i_read_data,
    output logic                       o_busy,
    output logic [1:0]                 o_mem_op,
    output logic [ADDR_BITS-1:0]       o_mem_address,
    output logic [31:0]                o_mem_write_data,
    output logic                       o_gpu_valid,
    output logic [31:0]                o_gpu_word,
    output logic                       o_done_res,
    output logic                       o_error
);

    logic                  r_busy,        n_busy;
    t_kind                 r_kind,        n_kind;
    logic                  r_in_payload,  n_in_payload;
    logic [ADDR_BITS-1:0]  r_cur_address, n_cur_address;
    logic [COUNT_BITS-1:0] r_remaining,   n_remaining;
    logic                  r_decrementing, n_decrementing;
    logic                  r_list_end,    n_list_end;
    logic [ADDR_BITS-1:0]  r_next_pointer, n_next_pointer;

    logic [ADDR_BITS-1:0]  w_start_al;
    logic [ADDR_BITS-1:0]  w_stepped;
    logic [ADDR_BITS-1:0]  w_ll_next;
    logic [ADDR_BITS-1:0]  w_hdr_ptr;
    logic [COUNT_BITS-1:0] w_rem_dec;
    logic                  w_start_bad;

    assign w_start_al = {i_start_address[ADDR_BITS-1:2], 2'b00};
    assign w_stepped  = r_decrementing ? (r_cur_address - ADDR_BITS'(4))
                                       : (r_cur_address + ADDR_BITS'(4));
    assign w_ll_next  = r_cur_address + ADDR_BITS'(4);
    assign w_hdr_ptr  = {i_read_data[ADDR_BITS-1:2], 2'b00};
    assign w_rem_dec  = r_remaining - COUNT_BITS'(1);
    assign w_start_bad = r_busy || (i_transfer_kind == KIND_UNUSED)
                       || ((i_transfer_kind != KIND_LIST) && (i_word_count == '0));

    // table-clear entry: link to the word below, or the end marker on the last
    function automatic logic [31:0] ot_entry(input logic [COUNT_BITS-1:0] rem,
                                             input logic [ADDR_BITS-1:0] addr);
        logic [ADDR_BITS-1:0] below;
        below = addr - ADDR_BITS'(4);
        return (rem == COUNT_BITS'(1)) ? OT_END : 32'(below);
    endfunction

    always_comb begin
        n_busy         = r_busy;
        n_kind         = r_kind;
        n_in_payload   = r_in_payload;
        n_cur_address  = r_cur_address;
        n_remaining    = r_remaining;
        n_decrementing = r_decrementing;
        n_list_end     = r_list_end;
        n_next_pointer = r_next_pointer;

        o_mem_op         = MEM_NONE;
        o_mem_address    = '0;
        o_mem_write_data = '0;
        o_gpu_valid      = 1'b0;
        o_gpu_word       = '0;
        o_done_res       = 1'b0;
        o_error          = 1'b0;

        if (!i_mode) begin
            if (w_start_bad) begin
                o_error = 1'b1;
            end else begin
                n_busy         = 1'b1;
                n_kind         = t_kind'(i_transfer_kind);
                n_in_payload   = 1'b0;
                n_list_end     = 1'b0;
                n_next_pointer = '0;
                n_decrementing = i_step_back;
                n_cur_address  = w_start_al;
                n_remaining    = (i_transfer_kind == KIND_LIST) ? '0 : i_word_count;
                o_mem_address  = w_start_al;
                if (i_transfer_kind == KIND_OTC) begin
                    o_mem_op         = MEM_WRITE;
                    o_mem_write_data = ot_entry(i_word_count, w_start_al);
                end else begin
                    o_mem_op = MEM_READ;
                end
            end
        end else if (!r_busy) begin
            o_error = 1'b1;
        end else begin
            unique case (r_kind)
                KIND_BLOCK: begin
                    n_remaining   = w_rem_dec;
                    n_cur_address = w_stepped;
                    o_gpu_valid   = 1'b1;
                    o_gpu_word    = i_read_data;
                    if (w_rem_dec == '0) begin
                        n_busy     = 1'b0;
                        o_done_res = 1'b1;
                    end else begin
                        o_mem_op      = MEM_READ;
                        o_mem_address = w_stepped;
                    end
                end
                KIND_OTC: begin
                    n_remaining   = w_rem_dec;
                    n_cur_address = w_stepped;
                    if (w_rem_dec == '0) begin
                        n_busy     = 1'b0;
                        o_done_res = 1'b1;
                    end else begin
                        o_mem_op         = MEM_WRITE;
                        o_mem_address    = w_stepped;
                        o_mem_write_data = ot_entry(w_rem_dec, w_stepped);
                    end
                end
                KIND_LIST: begin
                    if (!r_in_payload) begin
                        n_remaining    = COUNT_BITS'(i_read_data[31:LL_SIZE_LO]);
                        n_list_end     = i_read_data[LL_END_BIT];
                        n_next_pointer = w_hdr_ptr;
                    end else begin
                        o_gpu_valid = 1'b1;
                        o_gpu_word  = i_read_data;
                        n_remaining = w_rem_dec;
                    end
                    if (n_remaining != '0) begin
                        n_in_payload  = 1'b1;
                        n_cur_address = w_ll_next;
                        o_mem_op      = MEM_READ;
                        o_mem_address = w_ll_next;
                    end else if (n_list_end) begin
                        n_busy       = 1'b0;
                        n_in_payload = 1'b0;
                        o_done_res   = 1'b1;
                    end else begin
                        n_in_payload  = 1'b0;
                        n_cur_address = n_next_pointer;
                        o_mem_op      = MEM_READ;
                        o_mem_address = n_next_pointer;
                    end
                end
                default: begin
                    o_error = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_kind         <= KIND_BLOCK;
            r_in_payload   <= 1'b0;
            r_cur_address  <= '0;
            r_remaining    <= '0;
            r_decrementing <= 1'b0;
            r_list_end     <= 1'b0;
            r_next_pointer <= '0;
        end else if (i_fire) begin
            r_busy         <= n_busy;
            r_kind         <= n_kind;
            r_in_payload   <= n_in_payload;
            r_cur_address  <= n_cur_address;
            r_remaining    <= n_remaining;
            r_decrementing <= n_decrementing;
            r_list_end     <= n_list_end;
            r_next_pointer <= n_next_pointer;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire
